// ===== design/qfpl_pkg.sv =====
package qfpl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIAG,
    ST_CENTER,
    ST_VEC,
    ST_DOT,
    ST_DET,
    ST_TEST,
    ST_DIV,
    ST_DIVWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       diag_step;
    logic       center;
    logic       vec;
    logic       dot;
    logic       det;
    logic       div_start;
    logic       set_fallback;
    logic       set_result;
    logic       next_sector;
  } cmd_t;

  typedef struct packed {
    logic dot_fail;
    logic det_zero;
    logic ratio_fail;
    logic div_busy;
    logic diag_last;
    logic sector_last;
  } status_t;

  localparam int OUT_W = 11;
  localparam int SECTOR_W = 3;
  localparam logic [SECTOR_W-1:0] SECTOR_FALLBACK = 3'd4;
  localparam int DOT_MIN = -4;
  localparam int PCT_HALF = 50;
  localparam int OUT_MIN = -1024;
  localparam int OUT_MAX = 1023;

endpackage

// ===== design/qfpl_ctrl.sv =====
module qfpl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_busy,
  input  qfpl_pkg::status_t status,
  output qfpl_pkg::cmd_t    cmd,
  output logic              idle
);

  qfpl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qfpl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qfpl_pkg::ST_IDLE:    if (in_fire) state_next = qfpl_pkg::ST_DIAG;
      qfpl_pkg::ST_DIAG:    if (status.diag_last) state_next = qfpl_pkg::ST_CENTER;
      qfpl_pkg::ST_CENTER:  state_next = qfpl_pkg::ST_VEC;
      qfpl_pkg::ST_VEC:     state_next = qfpl_pkg::ST_DOT;
      qfpl_pkg::ST_DOT:     state_next = qfpl_pkg::ST_DET;
      qfpl_pkg::ST_DET:     state_next = qfpl_pkg::ST_TEST;
      qfpl_pkg::ST_TEST: begin
        if (status.dot_fail || (!status.det_zero && status.ratio_fail)) begin
          state_next = status.sector_last ? qfpl_pkg::ST_DONE : qfpl_pkg::ST_DOT;
        end else if (status.det_zero) begin
          state_next = qfpl_pkg::ST_DONE;
        end else begin
          state_next = qfpl_pkg::ST_DIV;
        end
      end
      qfpl_pkg::ST_DIV:     state_next = qfpl_pkg::ST_DIVWAIT;
      qfpl_pkg::ST_DIVWAIT: if (!status.div_busy) state_next = qfpl_pkg::ST_DONE;
      qfpl_pkg::ST_DONE:    if (!out_busy) state_next = qfpl_pkg::ST_IDLE;
      default:              state_next = qfpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      qfpl_pkg::ST_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
      end
      qfpl_pkg::ST_DIAG:   cmd.diag_step = 1'b1;
      qfpl_pkg::ST_CENTER: cmd.center = 1'b1;
      qfpl_pkg::ST_VEC:    cmd.vec = 1'b1;
      qfpl_pkg::ST_DOT:    cmd.dot = 1'b1;
      qfpl_pkg::ST_DET:    cmd.det = 1'b1;
      qfpl_pkg::ST_TEST: begin
        if (status.dot_fail || (!status.det_zero && status.ratio_fail)) begin
          cmd.next_sector = 1'b1;
          cmd.set_fallback = status.sector_last;
        end else if (status.det_zero) begin
          cmd.set_fallback = 1'b1;
        end
      end
      qfpl_pkg::ST_DIV:     cmd.div_start = 1'b1;
      qfpl_pkg::ST_DIVWAIT: cmd.set_result = !status.div_busy;
      qfpl_pkg::ST_DONE:    ;
      default:              ;
    endcase
  end

endmodule

// ===== design/qfpl_div.sv =====
// Two signed restoring dividers in lockstep, one quotient bit a cycle.
module qfpl_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num_a,
  input  logic signed [NUM_W-1:0] num_b,
  input  logic signed [DEN_W-1:0] den,
  output logic                    busy,
  output logic signed [NUM_W-1:0] quo_a,
  output logic signed [NUM_W-1:0] quo_b
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] qa, qb;
  logic [NUM_W-1:0] ra, rb;
  logic [NUM_W-1:0] dmag;
  logic             nega, negb;
  logic [NUM_W:0]   ta, tb;

  assign ta = {ra, qa[NUM_W-1]};
  assign tb = {rb, qb[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa <= num_a[NUM_W-1] ? NUM_W'(-num_a) : NUM_W'(num_a);
      qb <= num_b[NUM_W-1] ? NUM_W'(-num_b) : NUM_W'(num_b);
      dmag <= den[DEN_W-1] ? NUM_W'(-den) : NUM_W'(den);
      nega <= num_a[NUM_W-1] ^ den[DEN_W-1];
      negb <= num_b[NUM_W-1] ^ den[DEN_W-1];
      ra <= '0;
      rb <= '0;
    end else if (busy) begin
      if (ta >= {1'b0, dmag}) begin
        ra <= NUM_W'(ta - {1'b0, dmag});
        qa <= {qa[NUM_W-2:0], 1'b1};
      end else begin
        ra <= ta[NUM_W-1:0];
        qa <= {qa[NUM_W-2:0], 1'b0};
      end
      if (tb >= {1'b0, dmag}) begin
        rb <= NUM_W'(tb - {1'b0, dmag});
        qb <= {qb[NUM_W-2:0], 1'b1};
      end else begin
        rb <= tb[NUM_W-1:0];
        qb <= {qb[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo_a = nega ? -$signed(qa) : $signed(qa);
  assign quo_b = negb ? -$signed(qb) : $signed(qb);

endmodule

// ===== design/qfpl_dp.sv =====
module qfpl_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  qfpl_pkg::cmd_t                  cmd,
  input  logic [8*COORD_BITS-1:0]         corners,
  input  logic [COORD_BITS-1:0]           pos_x,
  input  logic [COORD_BITS-1:0]           pos_y,
  input  logic                            rst,
  output qfpl_pkg::status_t               status,
  output logic signed [qfpl_pkg::OUT_W-1:0] field_x,
  output logic signed [qfpl_pkg::OUT_W-1:0] field_y,
  output logic [qfpl_pkg::SECTOR_W-1:0]   sector
);

  // d and r span 4*coord - sum: COORD_BITS+3 bits signed
  localparam int VW = COORD_BITS + 4;
  localparam int PW = 2 * VW + 1;
  localparam int NW = PW + 8;

  logic [COORD_BITS-1:0] cx [4];
  logic [COORD_BITS-1:0] cy [4];
  logic [COORD_BITS-1:0] px, py;
  logic [1:0] diag, di;
  logic [2*COORD_BITS+1:0] best;
  logic [COORD_BITS+1:0] sx, sy;
  logic signed [VW-1:0] dx [4];
  logic signed [VW-1:0] dy [4];
  logic signed [VW-1:0] rx, ry;
  logic [1:0] sec, secj;
  logic signed [PW-1:0] dot1, dot2, dd, ss, tt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cx[k] = corners[(2*k)*COORD_BITS +: COORD_BITS];
      cy[k] = corners[(2*k+1)*COORD_BITS +: COORD_BITS];
    end
  end

  logic signed [COORD_BITS:0] ex, ey;
  logic signed [2*COORD_BITS+1:0] exx, eyy;
  logic [2*COORD_BITS+1:0] d2;
  assign ex = $signed({1'b0, cx[di]}) - $signed({1'b0, cx[0]});
  assign ey = $signed({1'b0, cy[di]}) - $signed({1'b0, cy[0]});
  // square at full width before the sum
  assign exx = ex * ex;
  assign eyy = ey * ey;
  assign d2 = $unsigned(exx) + $unsigned(eyy);
  assign status.diag_last = (di == 2'd3);
  assign secj = sec + 2'd1;
  assign status.sector_last = (sec == 2'd3);

  logic [1:0] oi [4];
  always_comb begin
    oi[0] = 2'd0; oi[1] = 2'd1; oi[2] = 2'd2; oi[3] = 2'd3;
    if (diag == 2'd1) begin
      oi[1] = 2'd2; oi[2] = 2'd1;
    end else if (diag == 2'd3) begin
      oi[2] = 2'd3; oi[3] = 2'd2;
    end
  end

  logic signed [NW-1:0] nx, ny, qx, qy;
  logic [0:0] pad;
  assign pad = 1'b0;

  function automatic logic signed [qfpl_pkg::OUT_W-1:0] sat(input logic signed [NW-1:0] v);
    if (v < NW'(qfpl_pkg::OUT_MIN)) sat = qfpl_pkg::OUT_W'(qfpl_pkg::OUT_MIN);
    else if (v > NW'(qfpl_pkg::OUT_MAX)) sat = qfpl_pkg::OUT_W'(qfpl_pkg::OUT_MAX);
    else sat = v[qfpl_pkg::OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x;
      py <= pos_y;
      di <= 2'd1;
      diag <= 2'd0;
      best <= '0;
      sec <= 2'd0;
    end
    if (cmd.diag_step) begin
      if (d2 > best) begin
        best <= d2;
        diag <= di;
      end
      di <= di + 2'd1;
    end
    if (cmd.center) begin
      sx <= (COORD_BITS+2)'(cx[0]) + cx[1] + cx[2] + cx[3];
      sy <= (COORD_BITS+2)'(cy[0]) + cy[1] + cy[2] + cy[3];
    end
    if (cmd.vec) begin
      for (int k = 0; k < 4; k++) begin
        dx[k] <= $signed({2'b0, cx[oi[k]], 2'b0}) - $signed({2'b0, sx});
        dy[k] <= $signed({2'b0, cy[oi[k]], 2'b0}) - $signed({2'b0, sy});
      end
      rx <= $signed({2'b0, px, 2'b0}) - $signed({2'b0, sx});
      ry <= $signed({2'b0, py, 2'b0}) - $signed({2'b0, sy});
    end
    if (cmd.dot) begin
      dot1 <= PW'(dx[sec] * rx) + PW'(dy[sec] * ry);
      dot2 <= PW'(dx[secj] * rx) + PW'(dy[secj] * ry);
    end
    if (cmd.det) begin
      dd <= PW'(dx[sec] * dy[secj]) - PW'(dy[sec] * dx[secj]);
      ss <= PW'(dy[secj] * rx) - PW'(dx[secj] * ry);
      tt <= PW'(dx[sec] * ry) - PW'(dy[sec] * rx);
    end
    if (cmd.next_sector) sec <= secj;
    if (cmd.set_fallback) begin
      field_x <= qfpl_pkg::OUT_W'(qfpl_pkg::PCT_HALF);
      field_y <= qfpl_pkg::OUT_W'(qfpl_pkg::PCT_HALF);
      sector <= qfpl_pkg::SECTOR_FALLBACK;
    end
    if (cmd.set_result) begin
      field_x <= sat(qx);
      field_y <= sat(qy);
      sector <= {pad, sec};
    end
  end

  assign status.dot_fail = (dot1 < PW'(qfpl_pkg::DOT_MIN)) || (dot2 < PW'(qfpl_pkg::DOT_MIN));
  assign status.det_zero = (dd == '0);
  assign status.ratio_fail =
    (dd[PW-1] ? (ss > 0) : ss[PW-1]) || (dd[PW-1] ? (tt > 0) : tt[PW-1]);

  logic signed [NW-1:0] de, se, te, nxs, nys;
  assign de = NW'(dd);
  assign se = NW'(ss);
  assign te = NW'(tt);
  always_comb begin
    case (sec)
      2'd0: begin nxs = de - se - te; nys = de - se + te; end
      2'd1: begin nxs = de - se + te; nys = de + se + te; end
      2'd2: begin nxs = de + se + te; nys = de + se - te; end
      default: begin nxs = de + se - te; nys = de - se - te; end
    endcase
  end
  // 50*n as shifts: 32n + 16n + 2n
  assign nx = (nxs <<< 5) + (nxs <<< 4) + (nxs <<< 1);
  assign ny = (nys <<< 5) + (nys <<< 4) + (nys <<< 1);

  qfpl_div #(.NUM_W(NW), .DEN_W(PW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_a (nx),
    .num_b (ny),
    .den   (dd),
    .busy  (status.div_busy),
    .quo_a (qx),
    .quo_b (qy)
  );

endmodule

// ===== design/quad_field_point_locator.sv =====
// Sequence: from the accepting edge, diagonal search, center, vectors, then dot, det and test
// per sector tried, then the divide, then res_ready, to m_tvalid; a 50,50 fallback skips the divide.
// Flow: one item at a time; s_tready rises the cycle after the result beat is taken.
// The bit-serial divider produces one quotient bit a cycle.
// Reset: rst is synchronous and active high; corners clear to zero, control goes idle.
module quad_field_point_locator #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x, pos_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // field_x, field_y, sector
  output logic [31:0]           m_tdata
);

  logic [8*COORD_BITS-1:0] corners;
  qfpl_pkg::cmd_t    cmd;
  qfpl_pkg::status_t status;
  logic idle, in_fire;
  logic signed [qfpl_pkg::OUT_W-1:0] fx, fy;
  logic [qfpl_pkg::SECTOR_W-1:0] sec;
  logic res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      corners <= '0;
    end else if (cfg_we) begin
      corners[cfg_index*COORD_BITS +: COORD_BITS] <= cfg_data;
    end
  end

  assign s_tready = idle && !m_tvalid;
  assign in_fire = s_tvalid && s_tready;

  qfpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_busy (1'b0),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle)
  );

  qfpl_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .corners (corners),
    .pos_x   (s_tdata[COORD_BITS-1:0]),
    .pos_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .rst     (rst),
    .status  (status),
    .field_x (fx),
    .field_y (fy),
    .sector  (sec)
  );

  // result is ready the cycle after the set command
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      res_ready <= cmd.set_result || cmd.set_fallback;
      if (res_ready) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, sec, fy, fx};

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.set_result && cmd.set_fallback)) else $error("two result commands");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (sec <= qfpl_pkg::SECTOR_FALLBACK)) else $error("bad sector");

endmodule
